// ===== sv/bfrd_pkg.sv =====
// bfrd_pkg: shared types and constants for the bus frame receiver dispatch block
// no dependencies
`timescale 1ns / 1ps

package bfrd_pkg;

    localparam int          NodeSlotsDefault = 16;
    localparam logic [7:0]  SyncByte         = 8'hA5;
    localparam logic [4:0]  HeaderRest       = 5'd17;
    localparam logic [47:0] BroadcastAddr    = 48'hFFFF_FFFF_FFFF;
    localparam logic [7:0]  TypeHello        = 8'd1;
    localparam logic [7:0]  TypeAction       = 8'd4;
    localparam logic [7:0]  TypeActionAck    = 8'd5;
    localparam logic [1:0]  KindHello        = 2'd0;
    localparam logic [1:0]  KindAction       = 2'd1;
    localparam logic [1:0]  KindAck          = 2'd2;
    // frame that completes without a result
    localparam logic [1:0]  KindNone         = 2'd3;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_HEADER,
        PH_PAYLOAD
    } t_phase;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_DONE
    } t_back_state;

    // completed frame handed from front to back
    typedef struct packed {
        logic [7:0]  frame_type;
        logic [15:0] payload_length;
        logic [47:0] source;
        logic        broadcast;
        logic [15:0] frame_id;
        logic [15:0] first_bytes;
    } t_frame;

    // result beat
    typedef struct packed {
        logic [1:0]  event_kind;
        logic [47:0] peer_address;
        logic [7:0]  peer_model;
        logic [4:0]  table_slot;
        logic        slot_is_new;
        logic [7:0]  output_number;
        logic [7:0]  output_command;
        logic        send_reply;
        logic [15:0] message_number;
    } t_result;

endpackage

// ===== sv/bfrd_ram.sv =====
// bfrd_ram: generic single-port-write, single-read ram with registered read
// no dependencies
`timescale 1ns / 1ps

module bfrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/bfrd_front.sv =====
// bfrd_front: byte parser, hunts sync, collects header and payload, filters destination
// depends on bfrd_pkg
`timescale 1ns / 1ps

module bfrd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_byte,
    input  logic [47:0]       i_self_address,
    output logic              o_frame_valid,
    input  logic              i_frame_ready,
    output bfrd_pkg::t_frame  o_frame
);

    bfrd_pkg::t_phase r_phase, n_phase;
    logic [15:0] r_pos;
    logic [7:0]  r_type;
    logic [15:0] r_len;
    logic [47:0] r_src;
    logic [47:0] r_dst;
    logic [15:0] r_id;
    logic [15:0] r_first;
    logic        r_fvalid;
    bfrd_pkg::t_frame r_frame;

    logic        w_acc;
    logic        w_done;
    logic [15:0] w_pos_inc;
    logic [15:0] w_len_now;
    logic [15:0] w_first_now;
    logic [15:0] w_id_now;
    logic [47:0] w_dst_now;
    logic        w_match;

    // one-entry hand-off register; stall bytes only when it is full and not drained
    assign o_ready       = !r_fvalid || i_frame_ready;
    assign w_acc         = i_valid && o_ready;
    assign w_pos_inc     = r_pos + 16'd1;
    assign o_frame_valid = r_fvalid;
    assign o_frame       = r_frame;

    // values including the current beat
    always_comb begin
        w_len_now   = r_len;
        w_id_now    = r_id;
        w_dst_now   = r_dst;
        w_first_now = r_first;
        if (r_phase == bfrd_pkg::PH_HEADER) begin
            if (r_pos == 16'd16) begin
                w_id_now = {i_byte, r_id[7:0]};
            end
            if (r_pos >= 16'd9 && r_pos <= 16'd14) begin
                w_dst_now = {r_dst[39:0], i_byte};
            end
            w_first_now = '0;
        end else if (r_phase == bfrd_pkg::PH_PAYLOAD) begin
            if (r_pos == 16'd0) begin
                w_first_now = {8'd0, i_byte};
            end else if (r_pos == 16'd1) begin
                w_first_now = {i_byte, r_first[7:0]};
            end
        end
    end

    assign w_match = (r_dst == i_self_address) || (r_dst == bfrd_pkg::BroadcastAddr);

    // frame completion on this beat
    always_comb begin
        w_done  = 1'b0;
        n_phase = r_phase;
        unique case (r_phase)
            bfrd_pkg::PH_HEADER: begin
                if (w_pos_inc[4:0] == bfrd_pkg::HeaderRest) begin
                    if (r_len == 16'd0) begin
                        n_phase = bfrd_pkg::PH_HUNT;
                        w_done  = 1'b1;
                    end else begin
                        n_phase = bfrd_pkg::PH_PAYLOAD;
                    end
                end
            end
            bfrd_pkg::PH_PAYLOAD: begin
                if (w_pos_inc == r_len) begin
                    n_phase = bfrd_pkg::PH_HUNT;
                    w_done  = 1'b1;
                end
            end
            default: begin
                n_phase = (i_byte == bfrd_pkg::SyncByte) ? bfrd_pkg::PH_HEADER
                                                         : bfrd_pkg::PH_HUNT;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= bfrd_pkg::PH_HUNT;
            r_pos    <= '0;
            r_fvalid <= 1'b0;
        end else begin
            if (w_acc && w_done && w_match) begin
                r_fvalid <= 1'b1;
            end else if (i_frame_ready) begin
                r_fvalid <= 1'b0;
            end
            if (w_acc) begin
                r_phase <= n_phase;
                if (r_phase == bfrd_pkg::PH_HEADER || r_phase == bfrd_pkg::PH_PAYLOAD) begin
                    r_pos <= (n_phase != r_phase) ? 16'd0 : w_pos_inc;
                end else begin
                    r_pos <= '0;
                end
            end
        end
    end

    // header and payload capture
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            unique case (r_phase)
                bfrd_pkg::PH_HEADER: begin
                    if (r_pos == 16'd0) begin
                        r_type <= i_byte;
                    end else if (r_pos == 16'd1) begin
                        r_len <= {8'd0, i_byte};
                    end else if (r_pos == 16'd2) begin
                        r_len <= {i_byte, r_len[7:0]};
                    end else if (r_pos <= 16'd8) begin
                        r_src <= {r_src[39:0], i_byte};
                    end else if (r_pos <= 16'd14) begin
                        r_dst <= w_dst_now;
                    end else if (r_pos == 16'd15) begin
                        r_id <= {8'd0, i_byte};
                    end else begin
                        r_id <= w_id_now;
                    end
                    r_first <= '0;
                end
                bfrd_pkg::PH_PAYLOAD: begin
                    r_first <= w_first_now;
                end
                default: begin
                    r_type  <= '0;
                    r_len   <= '0;
                    r_src   <= '0;
                    r_dst   <= '0;
                    r_id    <= '0;
                    r_first <= '0;
                end
            endcase
            if (w_done) begin
                r_frame.frame_type     <= r_type;
                r_frame.payload_length <= w_len_now;
                r_frame.source         <= r_src;
                r_frame.broadcast      <= (r_dst == bfrd_pkg::BroadcastAddr);
                r_frame.frame_id       <= w_id_now;
                r_frame.first_bytes    <= w_first_now;
            end
        end
    end

endmodule

// ===== sv/bfrd_back.sv =====
// bfrd_back: dispatches completed frames, scans the node table, builds results
// depends on bfrd_pkg and bfrd_ram
`timescale 1ns / 1ps

module bfrd_back #(
    parameter int NODE_SLOTS = bfrd_pkg::NodeSlotsDefault
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_frame_valid,
    output logic              o_frame_ready,
    input  bfrd_pkg::t_frame  i_frame,
    output logic              o_valid,
    input  logic              i_ready,
    output bfrd_pkg::t_result o_result
);

    localparam int AW = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
    localparam int RD = (NODE_SLOTS > 1) ? NODE_SLOTS : 2;
    localparam int FW = $clog2(NODE_SLOTS + 1);

    bfrd_pkg::t_back_state r_state, n_state;
    bfrd_pkg::t_frame  r_frame;
    bfrd_pkg::t_result r_res, n_res;
    logic              r_ovalid;
    logic [FW-1:0]     r_fill;
    logic [FW-1:0]     r_idx;
    logic              r_rd_live;
    logic [15:0]       r_reply;

    logic              w_take;
    logic              w_hit;
    logic              w_scan_end;
    logic              w_we;
    logic [47:0]       w_rdata;
    logic [7:0]        w_model;
    logic [FW-1:0]     w_prev;

    // take a new frame only once the previous result has left
    assign w_take        = i_frame_valid && !r_ovalid && r_state == bfrd_pkg::BK_IDLE;
    assign o_frame_ready = w_take;
    assign o_valid       = r_ovalid;
    assign o_result      = r_res;
    assign w_model       = (r_frame.payload_length == 16'd0) ? 8'd0 : r_frame.first_bytes[7:0];
    assign w_prev        = r_idx - FW'(1);
    // read data is registered behind the address: w_prev is the entry now on rdata
    assign w_hit         = r_rd_live && (w_rdata == r_frame.source);
    assign w_scan_end    = w_hit || (!r_rd_live && r_idx >= r_fill);
    assign w_we          = r_state == bfrd_pkg::BK_SCAN
                           && r_frame.frame_type == bfrd_pkg::TypeHello
                           && !w_hit && w_scan_end && (r_fill < FW'(NODE_SLOTS));

    bfrd_ram #(.WIDTH(48), .DEPTH(RD)) u_addr_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata (r_frame.source),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bfrd_pkg::BK_IDLE: begin
                if (w_take) begin
                    n_state = bfrd_pkg::BK_SCAN;
                end
            end
            bfrd_pkg::BK_SCAN: begin
                if (r_frame.frame_type != bfrd_pkg::TypeHello || w_scan_end) begin
                    n_state = bfrd_pkg::BK_DONE;
                end
            end
            bfrd_pkg::BK_DONE: begin
                n_state = bfrd_pkg::BK_IDLE;
            end
            default: n_state = bfrd_pkg::BK_IDLE;
        endcase
    end

    // result of the frame in hand
    always_comb begin
        n_res              = '0;
        n_res.peer_address = r_frame.source;
        n_res.event_kind   = bfrd_pkg::KindNone;
        case (r_frame.frame_type)
            bfrd_pkg::TypeHello: begin
                n_res.event_kind     = bfrd_pkg::KindHello;
                n_res.peer_model     = w_model;
                n_res.send_reply     = 1'b1;
                n_res.message_number = r_reply;
                if (w_hit) begin
                    n_res.table_slot = 5'(w_prev);
                end else if (r_fill < FW'(NODE_SLOTS)) begin
                    n_res.table_slot  = 5'(r_fill);
                    n_res.slot_is_new = 1'b1;
                end else begin
                    n_res.table_slot = 5'(NODE_SLOTS);
                end
            end
            bfrd_pkg::TypeAction: begin
                if (r_frame.payload_length == 16'd2) begin
                    n_res.event_kind     = bfrd_pkg::KindAction;
                    n_res.output_number  = r_frame.first_bytes[7:0];
                    n_res.output_command = r_frame.first_bytes[15:8];
                    n_res.send_reply     = !r_frame.broadcast;
                    n_res.message_number = r_frame.frame_id;
                end
            end
            bfrd_pkg::TypeActionAck: begin
                n_res.event_kind     = bfrd_pkg::KindAck;
                n_res.message_number = r_frame.frame_id;
            end
            default: ;
        endcase
    end

    // state, scan and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= bfrd_pkg::BK_IDLE;
            r_ovalid  <= 1'b0;
            r_fill    <= '0;
            r_reply   <= '0;
            r_idx     <= '0;
            r_rd_live <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == bfrd_pkg::BK_DONE) begin
                r_ovalid <= r_res.event_kind != bfrd_pkg::KindNone;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (w_take) begin
                r_idx     <= '0;
                r_rd_live <= 1'b0;
            end else if (r_state == bfrd_pkg::BK_SCAN) begin
                r_rd_live <= r_idx < r_fill;
                if (r_idx < r_fill) begin
                    r_idx <= r_idx + FW'(1);
                end
            end
            if (r_state == bfrd_pkg::BK_SCAN && r_frame.frame_type == bfrd_pkg::TypeHello
                && w_scan_end) begin
                r_reply <= r_reply + 16'd1;
                if (w_we) begin
                    r_fill <= r_fill + FW'(1);
                end
            end
        end
    end

    // payload of frame and result
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_frame <= i_frame;
        end
        if (r_state == bfrd_pkg::BK_SCAN && n_state == bfrd_pkg::BK_DONE) begin
            r_res <= n_res;
        end
    end

endmodule

// ===== sv/bus_frame_receiver_dispatch_core.sv =====
// bus_frame_receiver_dispatch_core: top level of the bus frame receiver
// depends on bfrd_pkg, bfrd_front, bfrd_back
`timescale 1ns / 1ps

// Usage
// Input channel i_valid/o_ready carries one received bus byte per beat on
// i_rx_byte. Output channel o_valid/i_ready carries one dispatch result per
// beat on the o_* fields. i_cfg_we writes the own station address from
// i_cfg_data; write it only while idle.
// The front parser takes one byte per cycle while its one-frame hand-off
// register is free. A completed frame then goes to the back end, which scans
// the node table memory one slot per cycle for a hello, then registers the
// result through its done state; other frames leave the scan state at once.
// The front keeps taking bytes of the next frame meanwhile; it stalls only
// while a completed frame waits in its hand-off register for the back end.
// A result waits in the output register until taken; while it waits the
// back end holds, and then the front fills and stalls.
// Reset clears the parser to sync hunting, the node count and reply counter
// to zero and the address to zero. The table memory needs no clearing: only
// entries below the fill count are read.

module bus_frame_receiver_dispatch_core #(
    parameter int NODE_SLOTS = bfrd_pkg::NodeSlotsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_cfg_we,
    input  logic [47:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_event_kind,
    output logic [47:0] o_peer_address,
    output logic [7:0]  o_peer_model,
    output logic [4:0]  o_table_slot,
    output logic        o_slot_is_new,
    output logic [7:0]  o_output_number,
    output logic [7:0]  o_output_command,
    output logic        o_send_reply,
    output logic [15:0] o_message_number
);

    logic [47:0]       r_self_address;
    logic              w_fvalid;
    logic              w_fready;
    bfrd_pkg::t_frame  w_frame;
    bfrd_pkg::t_result w_res;

    // address register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_self_address <= '0;
        end else if (i_cfg_we) begin
            r_self_address <= i_cfg_data;
        end
    end

    bfrd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_byte         (i_rx_byte),
        .i_self_address (r_self_address),
        .o_frame_valid  (w_fvalid),
        .i_frame_ready  (w_fready),
        .o_frame        (w_frame)
    );

    bfrd_back #(.NODE_SLOTS(NODE_SLOTS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame_valid (w_fvalid),
        .o_frame_ready (w_fready),
        .i_frame       (w_frame),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_result      (w_res)
    );

    assign o_event_kind     = w_res.event_kind;
    assign o_peer_address   = w_res.peer_address;
    assign o_peer_model     = w_res.peer_model;
    assign o_table_slot     = w_res.table_slot;
    assign o_slot_is_new    = w_res.slot_is_new;
    assign o_output_number  = w_res.output_number;
    assign o_output_command = w_res.output_command;
    assign o_send_reply     = w_res.send_reply;
    assign o_message_number = w_res.message_number;

endmodule

// ===== sv/bfrd_checker.sv =====
// bfrd_checker: port-level assertions for the receiver top level, with bind
// depends on bfrd_pkg and bus_frame_receiver_dispatch_core
`timescale 1ns / 1ps

module bfrd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_event_kind,
    input logic        o_slot_is_new,
    input logic        o_send_reply,
    input logic [7:0]  o_output_number,
    input logic [15:0] o_message_number
);

    // stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_message_number))
        else $error("result beat changed while stalled");

    // only three event kinds exist
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_event_kind != bfrd_pkg::KindNone)
        else $error("bad event kind");

    // a new slot only comes with a hello
    a_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_slot_is_new |-> o_event_kind == bfrd_pkg::KindHello)
        else $error("new slot outside hello");

    // hello always asks for a reply, ack never
    a_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_event_kind == bfrd_pkg::KindHello || o_event_kind == bfrd_pkg::KindAck)
        |-> o_send_reply == (o_event_kind == bfrd_pkg::KindHello))
        else $error("reply flag wrong");

    // output number only carried by action beats
    a_outnum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_event_kind != bfrd_pkg::KindAction |-> o_output_number == 8'd0)
        else $error("output number outside action");

endmodule

bind bus_frame_receiver_dispatch_core bfrd_checker u_bfrd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_event_kind     (o_event_kind),
    .o_slot_is_new    (o_slot_is_new),
    .o_send_reply     (o_send_reply),
    .o_output_number  (o_output_number),
    .o_message_number (o_message_number)
);
